/* hw/rtl/rotary_encoder_event_queue_core_macros.svh */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: assertion macros
// Shared concurrent assertion wrappers, clocked on clock; one is reset aware.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_EVENT_QUEUE_CORE_MACROS_SVH
`define ROTARY_ENCODER_EVENT_QUEUE_CORE_MACROS_SVH

// Assertion that is switched off while reset is high.
`define REEQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked during reset.
`define REEQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/reeq_pkg.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: package
// Shared widths, codes, state type and controller/datapath structs.
// ----------------------------------------------------------------------------
package reeq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int ACTION_W            = 2;
   localparam int TIME_W              = 32;
   localparam int LOCKOUT_W           = 10;
   localparam int STATUS_W            = 3;
   localparam int FILL_W              = 4;

   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 10'd70;

   // Action codes. Bit 1 set means a pop, so code three also pops.
   localparam logic [ACTION_W-1:0] ACT_EDGE_A = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_EDGE_B = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED     = 3'd0,
      ST_SUPPRESSED = 3'd1,
      ST_DROPPED    = 3'd2,
      ST_POPPED     = 3'd3,
      ST_EMPTY      = 3'd4
   } reeq_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } reeq_state_type;

   typedef struct packed {
      logic accept;   // capture the input word and read the queue head
      logic commit;   // update state and load the response register
   } reeq_cmd_type;

   typedef struct packed {
      logic out_blocked;  // response register holds a word not taken this cycle
   } reeq_stat_type;

endpackage

/* hw/rtl/reeq_req_if.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: request channel
// Valid/ready channel carrying one edge or pop request word.
// ----------------------------------------------------------------------------
interface reeq_req_if;
   import reeq_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIME_W-1:0]   time_ms;
   logic                sampled_level;

   modport source (output valid, output action, output time_ms, output sampled_level,
                   input ready);
   modport sink   (input valid, input action, input time_ms, input sampled_level,
                   output ready);
endinterface

/* hw/rtl/reeq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: response channel
// Valid/ready channel carrying one status word per request.
// ----------------------------------------------------------------------------
interface reeq_rsp_if;
   import reeq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                direction;
   logic [FILL_W-1:0]   fill_level;

   modport source (output valid, output status, output direction, output fill_level,
                   input ready);
   modport sink   (input valid, input status, input direction, input fill_level,
                   output ready);
endinterface

/* hw/rtl/rotary_encoder_event_queue_core.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue core
// Debounces encoder line edges, decodes them to a direction and queues them.
// ----------------------------------------------------------------------------
// Usage: each request word on req_chan is an edge on line A or B with its
// millisecond timestamp and sampled level, or a pop. Every request gives
// exactly one response word on rsp_chan with a status, a direction and the
// queue fill level after the request.
// A request is taken into the capture registers and committed later; the
// response word is loaded into the response register at commit. The block
// takes no new request until the last one is committed. The queue memory is
// read into a register at acceptance, so that the popped value is ready at
// commit. The response register parts the two channels: a response may wait
// while the next request is accepted, but that request is only committed
// once the waiting word has been taken, so a stalled receiver holds the
// block. Reset clears both edge times and both queue pointers and sets the
// lockout to its default of 70 ms; queue slots need no clearing. The lockout
// is written through csr_write_enable and csr_write_data; the user must do
// so only while the block idles, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rotary_encoder_event_queue_core #(
   parameter int QUEUE_DEPTH = reeq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [reeq_pkg::LOCKOUT_W-1:0] csr_write_data,
   reeq_req_if.sink                       req_chan,
   reeq_rsp_if.source                     rsp_chan
);
   import reeq_pkg::*;

   reeq_cmd_type  cmd;
   reeq_stat_type stat;

   // The sequencer decides when a word is taken and when it is committed.
   reeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds all state and the response register.
   reeq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_action        (req_chan.action),
      .req_time_ms       (req_chan.time_ms),
      .req_sampled_level (req_chan.sampled_level),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_direction     (rsp_chan.direction),
      .rsp_fill_level    (rsp_chan.fill_level),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

/* hw/rtl/reeq_ctrl.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: controller
// Two-state sequencer that takes a request and commits it once the
// response register is free.
// ----------------------------------------------------------------------------
module reeq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  reeq_pkg::reeq_stat_type stat,
   output reeq_pkg::reeq_cmd_type  cmd
);
   import reeq_pkg::*;

   reeq_state_type state_ff;
   reeq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* hw/rtl/reeq_datapath.sv */
// ----------------------------------------------------------------------------
// Rotary encoder event queue: datapath
// Lockout register, per-line edge times, ring queue memory with its
// pointers, and the response register.
// ----------------------------------------------------------------------------
`include "rotary_encoder_event_queue_core_macros.svh"

module reeq_datapath #(
   parameter int QUEUE_DEPTH = reeq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [reeq_pkg::LOCKOUT_W-1:0]    csr_write_data,
   input  logic [reeq_pkg::ACTION_W-1:0]     req_action,
   input  logic [reeq_pkg::TIME_W-1:0]       req_time_ms,
   input  logic                              req_sampled_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [reeq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_direction,
   output logic [reeq_pkg::FILL_W-1:0]       rsp_fill_level,
   input  reeq_pkg::reeq_cmd_type             cmd,
   output reeq_pkg::reeq_stat_type            stat
);
   import reeq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(QUEUE_DEPTH);

   logic [LOCKOUT_W-1:0] lockout_ff;
   logic [TIME_W-1:0]    last_a_ff;
   logic [TIME_W-1:0]    last_b_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic                 mem_ff [QUEUE_DEPTH];
   logic                 head_ff;

   logic [ACTION_W-1:0]  action_ff;
   logic [TIME_W-1:0]    time_ff;
   logic                 level_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic                 dir_ff;
   logic [FILL_W-1:0]    fill_ff;

   logic                 is_pop;
   logic                 is_a;
   logic                 empty;
   logic                 full;
   logic [TIME_W-1:0]    gap;
   logic                 gap_ok;
   logic                 do_push;
   logic                 do_pop;
   logic                 edge_dir;
   logic [PTR_W-1:0]     rd_step;
   logic [PTR_W-1:0]     wr_step;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W:0]       count;
   reeq_status_type      status_in;
   logic                 dir_in;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         lockout_ff <= csr_write_data;
      end
   end

   // Request capture; the queue head is read in the same cycle so that
   // the popped value is ready when the request is committed.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         time_ff   <= req_time_ms;
         level_ff  <= req_sampled_level;
         head_ff   <= mem_ff[rd_ptr_ff];
      end
   end

   always_comb begin
      rd_step   = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      wr_step   = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      is_pop    = action_ff[1];
      is_a      = (action_ff == ACT_EDGE_A);
      empty     = (rd_ptr_ff == wr_ptr_ff);
      full      = (wr_step == rd_ptr_ff);
      gap       = time_ff - (is_a ? last_a_ff : last_b_ff);
      gap_ok    = gap > TIME_W'(lockout_ff);
      edge_dir  = is_a ? ~level_ff : level_ff;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      dir_in    = edge_dir;
      if (is_pop) begin
         dir_in = 1'b0;
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_POPPED;
            dir_in    = head_ff;
            do_pop    = 1'b1;
         end
      end else if (!gap_ok) begin
         status_in = ST_SUPPRESSED;
      end else if (full) begin
         status_in = ST_DROPPED;
      end else begin
         status_in = ST_QUEUED;
         do_push   = 1'b1;
      end
      rd_ptr_in = do_pop  ? rd_step : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_step : wr_ptr_ff;
      if (wr_ptr_in >= rd_ptr_in) begin
         count = {1'b0, wr_ptr_in} - {1'b0, rd_ptr_in};
      end else begin
         count = {1'b0, wr_ptr_in} + DEPTH_EXT - {1'b0, rd_ptr_in};
      end
   end

   // Queue state and per-line edge times.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         last_a_ff <= '0;
         last_b_ff <= '0;
      end else if (cmd.commit) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         if (!is_pop && is_a) begin
            last_a_ff <= time_ff;
         end
         if (!is_pop && !is_a) begin
            last_b_ff <= time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_push) begin
         mem_ff[wr_ptr_ff] <= edge_dir;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         dir_ff    <= dir_in;
         fill_ff   <= FILL_W'(count);
      end
   end

   assign stat.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_direction    = dir_ff;
   assign rsp_fill_level   = fill_ff;

   `REEQ_ASSERT(a_commit_free, cmd.commit |-> !(rsp_valid_ff && !rsp_ready), "commit over busy word")
   `REEQ_ASSERT(a_commit_shows, cmd.commit |=> rsp_valid_ff, "committed response not shown")
   `REEQ_ASSERT(a_ptr_range, (rd_ptr_ff <= LAST_SLOT) && (wr_ptr_ff <= LAST_SLOT), "pointer range")
   `REEQ_ASSERT_ALWAYS(a_no_overlap, !(cmd.accept && cmd.commit), "accept and commit together")

endmodule
